// ----- src/dtms_pkg.sv -----
// ============================================================================
// dtms_pkg: shared types and constants for the duration text parser
// Character codes, parser phases, unit codes and the end-of-string snapshot
// that passes from the parser to the result stage.
// ============================================================================
`default_nettype none

package dtms_pkg;

    // Width of the saturating integer accumulator.
    localparam int ACC_BITS = 40;
    // Quotient of the accumulator by 1000; 1000 > 2^9, so nine bits fewer do.
    localparam int QUO_BITS = ACC_BITS - 9;
    // Rounded microsecond sum, wide enough for the quotient and a 32-bit compare.
    localparam int US_BITS  = (QUO_BITS + 1 > 33) ? QUO_BITS + 1 : 33;

    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
    localparam logic [QUO_BITS-1:0] QUO_SAT = QUO_BITS'(ACC_MAX / 1000);
    localparam logic [9:0]          REM_SAT = 10'(ACC_MAX % 1000);

    localparam logic [31:0] MSEC_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] MSEC_ERR  = 32'hFFFF_FFFF;
    localparam logic [21:0] SEC_LIMIT = 22'd2147484;
    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    localparam logic [9:0]  HALF_MS   = 10'd500;
    localparam logic [3:0]  HALF_DIG  = 4'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_M_UP  = 8'h4D;
    localparam logic [7:0] CH_S_UP  = 8'h53;
    localparam logic [7:0] CH_U_UP  = 8'h55;
    localparam logic [7:0] CH_M_LO  = 8'h6D;
    localparam logic [7:0] CH_S_LO  = 8'h73;
    localparam logic [7:0] CH_U_LO  = 8'h75;

    typedef enum logic [2:0] {
        PH_LEAD = 3'd0,
        PH_INT  = 3'd1,
        PH_FRAC = 3'd2,
        PH_SKIP = 3'd3,
        PH_POST = 3'd4,
        PH_UM   = 3'd5,
        PH_UU   = 3'd6,
        PH_DONE = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        UNIT_S  = 2'd0,
        UNIT_MS = 2'd1,
        UNIT_US = 2'd2
    } unit_t;

    // Parse state as it stands at the end of one string.
    typedef struct packed {
        logic                failed;
        unit_t               unit;
        logic [ACC_BITS-1:0] int_value;
        logic [QUO_BITS-1:0] quo;
        logic [9:0]          rem;
        logic [9:0]          frac_digits;
        logic [1:0]          frac_count;
        logic [3:0]          round_digit;
    } fin_t;

    // Weight that brings the held fraction digits to thousandths.
    function automatic logic [9:0] frac_scale(input logic [1:0] count);
        logic [9:0] s;
        unique case (count)
            2'd0:    s = 10'd1000;
            2'd1:    s = 10'd100;
            2'd2:    s = 10'd10;
            default: s = 10'd1;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- src/duration_text_to_msec.sv -----
// ============================================================================
// duration_text_to_msec: duration string to rounded milliseconds
// Channel    Dir  Signals                              Transfer
// item       in   ch[7:0], last                        item_valid & item_ready
// result     out  msec[31:0] (signed)                  msec_valid & msec_ready
//
// One character is taken every cycle unless the stages ahead stall; only a
// character marked last makes a result. The transfer of its final character
// fills the input register, then the parse state and snapshot are registered,
// then the result register.
// Reset clears the parse state and all valid flags; no clearing pass.
// A stalled result holds the snapshot, then a final character in the input register, then ready.
// ============================================================================
`default_nettype none

module duration_text_to_msec (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         ch,
    input  wire logic               last,
    input  wire logic               item_valid,
    output logic                    item_ready,
    output logic signed [31:0]      msec,
    output logic                    msec_valid,
    input  wire logic               msec_ready
);
    import dtms_pkg::*;

    logic               in_valid_reg;
    logic [7:0]         ch_reg;
    logic               last_reg;
    logic               take;
    logic               fin_valid;
    logic               fin_ready;
    fin_t               fin;
    logic               out_en;
    logic               out_valid_reg;
    logic signed [31:0] msec_reg;
    logic [31:0]        msec_next;

    logic [9:0]         frac_ms;
    logic [32:0]        sec_sum;
    logic [US_BITS-1:0] us_sum;

    assign item_ready = !in_valid_reg || take;
    assign out_en     = !out_valid_reg || msec_ready;
    assign fin_ready  = !fin_valid || out_en;
    assign msec       = msec_reg;
    assign msec_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_valid && item_ready)
            in_valid_reg <= 1'b1;
        else if (take)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
    end

    dtms_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_ch    (ch_reg),
        .item_last  (last_reg),
        .fin_ready  (fin_ready),
        .item_take  (take),
        .fin_valid  (fin_valid),
        .fin        (fin)
    );

    always_comb
    begin
        // Held fraction digits never exceed 999 thousandths.
        frac_ms = 10'(fin.frac_digits * frac_scale(fin.frac_count));
        sec_sum = 33'(fin.int_value[21:0]) * 33'(MS_PER_S) + 33'(frac_ms)
                + 33'(fin.round_digit >= HALF_DIG);
        us_sum  = US_BITS'(fin.quo) + US_BITS'(fin.rem >= HALF_MS);

        if (fin.failed)
            msec_next = MSEC_ERR;
        else
        begin
            unique case (fin.unit)
                UNIT_MS:
                begin
                    if (fin.int_value >= ACC_BITS'(MSEC_MAX))
                        msec_next = MSEC_MAX;
                    else
                        msec_next = 32'(fin.int_value[30:0]) + 32'(frac_ms >= HALF_MS);
                end
                UNIT_US:
                begin
                    if (us_sum > US_BITS'(MSEC_MAX))
                        msec_next = MSEC_MAX;
                    else
                        msec_next = us_sum[31:0];
                end
                default:
                begin
                    if (fin.int_value >= ACC_BITS'(SEC_LIMIT))
                        msec_next = MSEC_MAX;
                    else if (sec_sum > 33'(MSEC_MAX))
                        msec_next = MSEC_MAX;
                    else
                        msec_next = sec_sum[31:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= fin_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && fin_valid)
            msec_reg <= msec_next;
    end

`ifndef SYNTHESIS
    a_msec_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (msec_reg == -32'sd1) || !msec_reg[31])
        else $error("result below -1");

    a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && !out_en |=> fin_valid && $stable(fin))
        else $error("end-of-string snapshot lost under stall");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> in_valid_reg)
        else $error("character consumed from an empty input register");
`endif

endmodule

`default_nettype wire

// ----- src/dtms_parse.sv -----
// ============================================================================
// dtms_parse: character-level parser
// Updates the parse state with one character per cycle (a final character waits while
// a snapshot is held) and, on the final character, registers the snapshot and clears.
// ============================================================================
`default_nettype none

module dtms_parse (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic [7:0]    item_ch,
    input  wire logic          item_last,
    input  wire logic          fin_ready,
    output logic               item_take,
    output logic               fin_valid,
    output dtms_pkg::fin_t     fin
);
    import dtms_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [ACC_BITS-1:0] int_value_reg, int_value_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [9:0]          rem_reg, rem_next;
    logic [9:0]          frac_digits_reg, frac_digits_next;
    logic [1:0]          frac_count_reg, frac_count_next;
    logic [3:0]          round_digit_reg, round_digit_next;
    unit_t               unit_reg, unit_next;
    logic                failed_reg, failed_next;
    logic                fin_valid_reg;
    fin_t                fin_reg, fin_next;

    logic                is_digit, is_space, is_dot;
    logic [3:0]          dig;
    phase_t              an_phase;
    logic                an_fail;
    logic [ACC_BITS+3:0] acc_x10;
    logic                acc_sat;
    logic [13:0]         rem_x10;
    logic [3:0]          quo_dig;
    logic [QUO_BITS+3:0] quo_x10;
    logic [13:0]         frac_x10;

    assign item_take = item_valid && (!item_last || fin_ready);
    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    always_comb
    begin
        is_digit = (item_ch >= CH_0) && (item_ch <= CH_9);
        is_dot   = (item_ch == CH_DOT);
        is_space = (item_ch == CH_SPACE) || (item_ch == CH_TAB) || (item_ch == CH_LF)
                || (item_ch == CH_CR) || (item_ch == CH_FF);
        dig      = item_ch[3:0];

        // What follows a finished number: whitespace, unit letter or end; anything else fails.
        an_fail  = 1'b0;
        if (is_space)
            an_phase = PH_POST;
        else if ((item_ch == CH_M_LO) || (item_ch == CH_M_UP))
            an_phase = PH_UM;
        else if ((item_ch == CH_U_LO) || (item_ch == CH_U_UP))
            an_phase = PH_UU;
        else if (item_ch == CH_NUL)
            an_phase = PH_DONE;
        else
        begin
            an_phase = PH_DONE;
            an_fail  = 1'b1;
        end

        // Integer accumulate; the top four bits flag an overflow past the maximum.
        acc_x10 = {int_value_reg, 3'b000} + {2'b00, int_value_reg, 1'b0}
                + (ACC_BITS+4)'(dig);
        acc_sat = |acc_x10[ACC_BITS+3:ACC_BITS];

        // The quotient and remainder by 1000 follow the accumulator one digit at a time.
        rem_x10 = {rem_reg, 3'b000} + {3'b000, rem_reg, 1'b0} + 14'(dig);
        quo_dig = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_x10 >= 14'(k * 1000))
                quo_dig = 4'(k);
        end
        quo_x10  = {quo_reg, 3'b000} + {2'b00, quo_reg, 1'b0} + (QUO_BITS+4)'(quo_dig);
        frac_x10 = {1'b0, frac_digits_reg, 3'b000} + {3'b000, frac_digits_reg, 1'b0}
                 + 14'(dig);
    end

    always_comb
    begin
        phase_next       = phase_reg;
        int_value_next   = int_value_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        frac_digits_next = frac_digits_reg;
        frac_count_next  = frac_count_reg;
        round_digit_next = round_digit_reg;
        unit_next        = unit_reg;
        failed_next      = failed_reg;

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (is_digit)
                begin
                    int_value_next = ACC_BITS'(dig);
                    quo_next       = '0;
                    rem_next       = 10'(dig);
                    phase_next     = PH_INT;
                end
                else if (is_dot)
                    phase_next = PH_FRAC;
                else if (item_ch == CH_NUL)
                    phase_next = PH_DONE;
                else if (!is_space)
                begin
                    phase_next  = PH_DONE;
                    failed_next = 1'b1;
                end
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    if (acc_sat)
                    begin
                        int_value_next = ACC_MAX;
                        quo_next       = QUO_SAT;
                        rem_next       = REM_SAT;
                    end
                    else
                    begin
                        int_value_next = acc_x10[ACC_BITS-1:0];
                        quo_next       = quo_x10[QUO_BITS-1:0];
                        rem_next       = 10'(rem_x10 - 14'(quo_dig) * 14'(MS_PER_S));
                    end
                end
                else if (is_dot)
                    phase_next = PH_FRAC;
                else
                begin
                    phase_next  = an_phase;
                    failed_next = failed_reg | an_fail;
                end
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    if (frac_count_reg < 2'd3)
                    begin
                        frac_digits_next = frac_x10[9:0];
                        frac_count_next  = frac_count_reg + 2'd1;
                    end
                    else
                    begin
                        round_digit_next = dig;
                        phase_next       = PH_SKIP;
                    end
                end
                else if (is_dot)
                    phase_next = PH_SKIP;
                else
                begin
                    phase_next  = an_phase;
                    failed_next = failed_reg | an_fail;
                end
            end
            PH_SKIP:
            begin
                if (!is_digit && !is_dot)
                begin
                    phase_next  = an_phase;
                    failed_next = failed_reg | an_fail;
                end
            end
            PH_POST:
            begin
                phase_next  = an_phase;
                failed_next = failed_reg | an_fail;
            end
            PH_UM, PH_UU:
            begin
                phase_next = PH_DONE;
                if ((item_ch == CH_S_LO) || (item_ch == CH_S_UP))
                    unit_next = (phase_reg == PH_UM) ? UNIT_MS : UNIT_US;
                else
                    failed_next = 1'b1;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // The end of the string leaves a half-read unit as an error.
        fin_next.failed      = failed_next || (phase_next == PH_UM) || (phase_next == PH_UU);
        fin_next.unit        = unit_next;
        fin_next.int_value   = int_value_next;
        fin_next.quo         = quo_next;
        fin_next.rem         = rem_next;
        fin_next.frac_digits = frac_digits_next;
        fin_next.frac_count  = frac_count_next;
        fin_next.round_digit = round_digit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            int_value_reg   <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            frac_digits_reg <= '0;
            frac_count_reg  <= '0;
            round_digit_reg <= '0;
            unit_reg        <= UNIT_S;
            failed_reg      <= 1'b0;
        end
        else if (item_take)
        begin
            if (item_last)
            begin
                phase_reg       <= PH_LEAD;
                int_value_reg   <= '0;
                quo_reg         <= '0;
                rem_reg         <= '0;
                frac_digits_reg <= '0;
                frac_count_reg  <= '0;
                round_digit_reg <= '0;
                unit_reg        <= UNIT_S;
                failed_reg      <= 1'b0;
            end
            else
            begin
                phase_reg       <= phase_next;
                int_value_reg   <= int_value_next;
                quo_reg         <= quo_next;
                rem_reg         <= rem_next;
                frac_digits_reg <= frac_digits_next;
                frac_count_reg  <= frac_count_next;
                round_digit_reg <= round_digit_next;
                unit_reg        <= unit_next;
                failed_reg      <= failed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (fin_ready)
            fin_valid_reg <= item_take && item_last;
    end

    always_ff @(posedge clk)
    begin
        if (item_take && item_last)
            fin_reg <= fin_next;
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && item_last |=> phase_reg == PH_LEAD && int_value_reg == '0
                                   && !failed_reg)
        else $error("parse state not cleared after the final character");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < MS_PER_S)
        else $error("remainder by 1000 out of range");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        frac_digits_reg < MS_PER_S)
        else $error("held fraction digits out of range");
`endif

endmodule

`default_nettype wire

// ----- test/duration_text_to_msec_test.sv -----
// ============================================================================
// duration_text_to_msec_test: self-checking bench for the duration parser
// Characters are streamed in one transfer at a time, with random gaps on the
// item side and random stalls on the result side. A behavioral parser in the
// scoreboard predicts each millisecond value. Each received result is
// compared with the oldest prediction.
// ============================================================================
`default_nettype none

module duration_text_to_msec_test;

    import dtms_pkg::*;

    // Predicts the parser's output and checks each received result.
    class msec_scoreboard;
        phase_t              ph;
        logic [ACC_BITS-1:0] acc;
        logic [9:0]          frac;
        logic [1:0]          nfrac;
        logic [3:0]          rdig;
        unit_t               unit;
        bit                  bad;
        logic [31:0]         expected_msec[$];
        int                  errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            ph    = PH_LEAD;
            acc   = '0;
            frac  = '0;
            nfrac = '0;
            rdig  = '0;
            unit  = UNIT_S;
            bad   = 1'b0;
        endfunction

        function bit is_ws(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
        endfunction

        function bit is_dig(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function void set_failed();
            bad = 1'b1;
            ph  = PH_DONE;
        endfunction

        // Handles whatever follows the number: blanks, a unit prefix or the end; anything else fails.
        function void after_num(logic [7:0] c);
            ph = PH_POST;
            if (is_ws(c))
                return;
            if (c == CH_M_LO || c == CH_M_UP)
                ph = PH_UM;
            else if (c == CH_U_LO || c == CH_U_UP)
                ph = PH_UU;
            else if (c == CH_NUL)
                ph = PH_DONE;
            else
                set_failed();
        endfunction

        function void consume(logic [7:0] c);
            logic [63:0] d;
            logic [63:0] lim;
            d   = 64'(c - CH_0);
            lim = (64'(ACC_MAX) - d) / 10;
            case (ph)
                PH_LEAD:
                begin
                    if (is_ws(c))
                        return;
                    if (is_dig(c))
                    begin
                        acc = ACC_BITS'(d);
                        ph  = PH_INT;
                    end
                    else if (c == CH_DOT)
                        ph = PH_FRAC;
                    else if (c == CH_NUL)
                        ph = PH_DONE;
                    else
                        set_failed();
                end
                PH_INT:
                begin
                    if (is_dig(c))
                    begin
                        if (64'(acc) > lim)
                            acc = ACC_MAX;
                        else
                            acc = ACC_BITS'(64'(acc) * 10 + d);
                    end
                    else if (c == CH_DOT)
                        ph = PH_FRAC;
                    else
                        after_num(c);
                end
                PH_FRAC:
                begin
                    if (is_dig(c))
                    begin
                        if (nfrac < 2'd3)
                        begin
                            frac  = 10'(frac * 10 + d);
                            nfrac = nfrac + 2'd1;
                        end
                        else
                        begin
                            rdig = 4'(d);
                            ph   = PH_SKIP;
                        end
                    end
                    else if (c == CH_DOT)
                        ph = PH_SKIP;
                    else
                        after_num(c);
                end
                PH_SKIP:
                begin
                    if (!is_dig(c) && c != CH_DOT)
                        after_num(c);
                end
                PH_POST:
                    after_num(c);
                PH_UM, PH_UU:
                begin
                    if (c == CH_S_LO || c == CH_S_UP)
                    begin
                        unit = (ph == PH_UM) ? UNIT_MS : UNIT_US;
                        ph   = PH_DONE;
                    end
                    else
                        set_failed();
                end
                default:
                    ;
            endcase
        endfunction

        // Milliseconds from the finished parse, rounded half up and saturated.
        function logic [31:0] duration();
            logic [63:0] i;
            logic [63:0] f;
            logic [63:0] v;
            i = 64'(acc);
            case (nfrac)
                2'd0:    f = 64'(frac) * 1000;
                2'd1:    f = 64'(frac) * 100;
                2'd2:    f = 64'(frac) * 10;
                default: f = 64'(frac);
            endcase
            if (bad)
                return MSEC_ERR;
            if (unit == UNIT_MS)
            begin
                if (i >= 64'(MSEC_MAX))
                    return MSEC_MAX;
                v = i + ((f >= 64'(HALF_MS)) ? 64'd1 : 64'd0);
            end
            else if (unit == UNIT_US)
                v = i / 64'(MS_PER_S) + (((i % 64'(MS_PER_S)) >= 64'(HALF_MS)) ? 64'd1 : 64'd0);
            else
            begin
                if (i >= 64'(SEC_LIMIT))
                    return MSEC_MAX;
                v = i * 64'(MS_PER_S) + f + ((rdig >= HALF_DIG) ? 64'd1 : 64'd0);
            end
            return (v > 64'(MSEC_MAX)) ? MSEC_MAX : v[31:0];
        endfunction

        function void note_input(logic [7:0] c, logic l);
            consume(c);
            if (l)
            begin
                consume(CH_NUL);
                expected_msec.push_back(duration());
                clear();
            end
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (expected_msec.size() == 0)
            begin
                $error("msec: no result expected, got %0d", $signed(got));
                errors++;
                return;
            end
            want = expected_msec.pop_front();
            if (got !== want)
            begin
                $error("msec: expected %0d, got %0d", $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic [7:0]         ch;
    logic               last;
    logic               item_valid;
    logic               item_ready;
    logic signed [31:0] msec;
    logic               msec_valid;
    logic               msec_ready;

    msec_scoreboard sb = new();
    bit             calm = 1'b0;
    int             chars_sent = 0;

    duration_text_to_msec DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch         (ch),
        .last       (last),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .msec       (msec),
        .msec_valid (msec_valid),
        .msec_ready (msec_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random back-pressure, except in the calm stretch.
    initial
    begin
        msec_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (msec_valid && msec_ready)
                sb.check_result(msec);
            msec_ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // One character transfer; valid stays up into the next call unless it idles.
    task automatic send_char(input logic [7:0] c, input logic l);
        while (!calm && $urandom_range(99) < 23)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        ch         <= c;
        last       <= l;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_input(c, l);
        chars_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(9));
    endfunction

    // Mostly well-formed durations with random content; the rest is noise.
    task automatic send_random_string();
        logic [7:0] q[$];
        int         n;
        if ($urandom_range(99) < 80)
        begin
            repeat ($urandom_range(2))
                q.push_back(rand_ws());
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 4);
            repeat (n)
                q.push_back(rand_digit());
            if ($urandom_range(2) != 0)
            begin
                q.push_back(CH_DOT);
                repeat ($urandom_range(5))
                    q.push_back(rand_digit());
                if ($urandom_range(9) == 0)
                begin
                    q.push_back(CH_DOT);
                    repeat ($urandom_range(3))
                        q.push_back(rand_digit());
                end
            end
            repeat ($urandom_range(1))
                q.push_back(rand_ws());
            case ($urandom_range(5))
                2:
                begin
                    q.push_back($urandom_range(1) ? CH_M_UP : CH_M_LO);
                    q.push_back($urandom_range(1) ? CH_S_UP : CH_S_LO);
                end
                3:
                begin
                    q.push_back($urandom_range(1) ? CH_U_UP : CH_U_LO);
                    q.push_back($urandom_range(1) ? CH_S_UP : CH_S_LO);
                end
                4:
                begin
                    q.push_back($urandom_range(1) ? CH_M_LO : CH_U_UP);
                    if ($urandom_range(1))
                        q.push_back(8'($urandom_range(255)));
                end
                5:
                    q.push_back(8'($urandom_range(255)));
                default:
                    ;
            endcase
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 2))
                    q.push_back(8'($urandom_range(255)));
            if ($urandom_range(3) == 0)
            begin
                q.push_back(CH_NUL);
                repeat ($urandom_range(2))
                    q.push_back(8'($urandom_range(255)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                q.push_back(8'($urandom_range(255)));
        end
        if (q.size() == 0)
            q.push_back(CH_NUL);
        for (int i = 0; i < q.size(); i++)
            send_char(q[i], i == q.size() - 1);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        ch         <= CH_NUL;
        last       <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty string, blank string and a number with no digits.
        send_char(CH_NUL, 1'b1);
        send_char(CH_SPACE, 1'b1);
        send_str(".");
        send_str("\t1.5mS");
        send_str("1500Us");
        send_str("0.0005");
        send_str("1.2.3 ms");
        // Incomplete unit and stray bytes are syntax errors.
        send_str("7m");
        send_char(8'h0B, 1'b1);
        send_char(8'hFF, 1'b1);
        // Bytes after the zero byte are ignored up to the last one.
        send_char(CH_0 + 8'd9, 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char(8'h80, 1'b1);

        while (chars_sent < 1700)
        begin
            calm = (chars_sent >= 600 && chars_sent < 900);
            send_random_string();
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        while (sb.expected_msec.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
